FILE: rtl/pwom_pkg.sv
// Package for the projective warp overlap mask core: opcodes, register
// indexes, default sizes, sequencer states and the divider status type.
// No dependencies.
package pwom_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MAX_DIM_DEF     = 4096;
  localparam int GRID_MAX_DEF    = 64;
  localparam int COEFF_WIDTH_DEF = 64;

  // Fixed field limits
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
  localparam logic [12:0] BND_MAX = 13'd8191;

  // Input item opcodes
  typedef enum logic [2:0] {
    OP_LOAD_COEF = 3'd0,
    OP_LOAD_COL  = 3'd1,
    OP_LOAD_ROW  = 3'd2,
    OP_MAP       = 3'd3,
    OP_CLEAR     = 3'd4
  } pwom_op_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_GRID_MODE     = 3'd0;
  localparam logic [2:0] CFG_OFFSET_X      = 3'd1;
  localparam logic [2:0] CFG_OFFSET_Y      = 3'd2;
  localparam logic [2:0] CFG_TARGET_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_TARGET_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_GRID_COLUMNS  = 3'd5;
  localparam logic [2:0] CFG_GRID_ROWS     = 3'd6;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SRD   = 12'b000000000010,
    S_SCMP  = 12'b000000000100,
    S_CELL  = 12'b000000001000,
    S_TRD   = 12'b000000010000,
    S_TMUL  = 12'b000000100000,
    S_TACC  = 12'b000001000000,
    S_P1    = 12'b000010000000,
    S_P2    = 12'b000100000000,
    S_P3    = 12'b001000000000,
    S_DIV   = 12'b010000000000,
    S_CHECK = 12'b100000000000
  } pwom_state_e;

  // Divider status towards the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } pwom_div_sts_t;

endpackage

FILE: rtl/projective_warp_overlap_mask_core.sv
// Projective warp overlap mask core: sequencer, shared multiply-accumulate, boundary
// search and result register. Depends on pwom_pkg, pwom_ram and pwom_div.
// Loads and clears are taken in idle. A map item runs the multiply-accumulate over nine
// coefficients, two divisions and the bounds check before it loads the result, after a
// boundary search over columns and then rows in grid mode; the input stalls until the
// item is done, and a stalled result holds the sequencer.
// Reset clears configuration, counter and control registers, not payload or tables.
module projective_warp_overlap_mask_core #(
  parameter int MAX_DIM     = pwom_pkg::MAX_DIM_DEF,
  parameter int GRID_MAX    = pwom_pkg::GRID_MAX_DEF,
  parameter int COEFF_WIDTH = pwom_pkg::COEFF_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] table_index_i,
  input  logic [63:0] load_value_i,
  input  logic [11:0] pixel_col_i,
  input  logic [11:0] pixel_row_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        matched_o,
  output logic [11:0] target_col_o,
  output logic [11:0] target_row_o,
  output logic [23:0] match_number_o,
  output logic [11:0] source_col_o,
  output logic [11:0] source_row_o
);
  import pwom_pkg::*;

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int SLOTS = 9 * CELLS;
  localparam int CAW   = $clog2(SLOTS);
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int BAW   = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int KW    = $clog2(GRID_MAX + 1);
  localparam int PW    = COEFF_WIDTH + 16;
  localparam int AW    = COEFF_WIDTH + 18;
  localparam int DW    = AW + 2;
  localparam int QB    = $clog2(MAX_DIM);
  localparam int RW    = QB + 1;

  // Configuration registers
  logic               mode_q;
  logic signed [13:0] offx_q, offy_q;
  logic [12:0]        tw_q, th_q;
  logic [6:0]         gcols_q, grows_q;

  // Sequencer and item state
  pwom_state_e           state_q, state_d;
  logic [11:0]           col_q, col_d, row_q, row_d;
  logic signed [15:0]    u_q, u_d, v_q, v_d;
  logic [KW-1:0]         k_q, k_d, xi_q, xi_d, yi_q, yi_d;
  logic                  srow_q, srow_d;
  logic [CW-1:0]         cell_q, cell_d;
  logic [1:0]            tk_q, tk_d, tm_q, tm_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic signed [AW-1:0]  t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic                  nsel_q, nsel_d;
  logic signed [DW-1:0]  n_q, n_d, d_q, d_d;
  logic [RW-1:0]         p_q, p_d, q_q, q_d;
  logic                  fail_q, fail_d;
  logic [23:0]           cnt_q, cnt_d;

  // Result register
  logic        ov_q, ov_d;
  logic        om_q, om_d;
  logic [11:0] otc_q, otc_d, otr_q, otr_d, osc_q, osc_d, osr_q, osr_d;
  logic [23:0] omn_q, omn_d;

  // Memory and divider connections
  logic                   accept;
  logic                   coef_we, coef_re;
  logic [CAW-1:0]         coef_raddr;
  logic [COEFF_WIDTH-1:0] coef_rd;
  logic                   cb_we, rb_we, bnd_re;
  logic [12:0]            bnd_wdata, cb_rd, rb_rd;
  logic                   div_start;
  logic [DW-1:0]          div_num;
  pwom_div_sts_t          div_sts;
  logic [QB-1:0]          div_quo;

  // Derived values
  logic [KW-1:0]         gc, gr, srch_n, k_inc, srch_idx;
  logic [12:0]           srch_bnd, srch_pos;
  logic [3:0]            slot;
  logic signed [15:0]    mult;
  logic signed [AW-1:0]  acc_sum, num_s;
  logic [RW-1:0]         res;
  logic [31:0]           low, tw_eff, th_eff;
  logic                  hit, out_free;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Clamp grid counts to 1..GRID_MAX
  always_comb begin
    if (gcols_q == 7'd0) begin
      gc = KW'(1);
    end else if (32'(gcols_q) > GRID_MAX) begin
      gc = KW'(GRID_MAX);
    end else begin
      gc = KW'(gcols_q);
    end
    if (grows_q == 7'd0) begin
      gr = KW'(1);
    end else if (32'(grows_q) > GRID_MAX) begin
      gr = KW'(GRID_MAX);
    end else begin
      gr = KW'(grows_q);
    end
  end

  // Saturate boundary loads to 0..8191
  always_comb begin
    if (load_value_i[63]) begin
      bnd_wdata = '0;
    end else if (load_value_i > 64'(BND_MAX)) begin
      bnd_wdata = BND_MAX;
    end else begin
      bnd_wdata = load_value_i[12:0];
    end
  end

  assign coef_we = accept && (opcode_i == OP_LOAD_COEF) && (32'(table_index_i) < SLOTS);
  assign cb_we   = accept && (opcode_i == OP_LOAD_COL) && (32'(table_index_i) < GRID_MAX);
  assign rb_we   = accept && (opcode_i == OP_LOAD_ROW) && (32'(table_index_i) < GRID_MAX);
  assign bnd_re  = (state_q == S_SRD);
  assign coef_re = (state_q == S_TRD);

  // Search helpers
  assign srch_bnd = srow_q ? rb_rd : cb_rd;
  assign srch_pos = srow_q ? {1'b0, row_q} : {1'b0, col_q};
  assign srch_n   = srow_q ? gr : gc;
  assign k_inc    = k_q + KW'(1);

  // Coefficient slot k + 3m
  assign slot       = {2'b00, tk_q} + 4'(3 * tm_q);
  assign coef_raddr = CAW'(32'(cell_q) + 32'(slot) * CELLS);
  assign mult       = (tm_q == 2'd0) ? u_q : ((tm_q == 2'd1) ? v_q : 16'sd1);
  assign acc_sum    = acc_q + AW'(prod_q);
  assign num_s      = nsel_q ? t1_q : t0_q;

  assign div_num = DW'(n_q) - DW'(1);
  assign res     = RW'(div_quo) + RW'(1);

  // Bounds check
  assign low    = mode_q ? 32'd1 : 32'd2;
  assign tw_eff = (32'(tw_q) > MAX_DIM) ? 32'(MAX_DIM) : 32'(tw_q);
  assign th_eff = (32'(th_q) > MAX_DIM) ? 32'(MAX_DIM) : 32'(th_q);
  assign hit    = ~fail_q && (32'(p_q) >= low) && (32'(p_q) < tw_eff)
               && (32'(q_q) >= low) && (32'(q_q) < th_eff);
  assign out_free = ~ov_q | ~out_stall_i;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    u_d       = u_q;
    v_d       = v_q;
    k_d       = k_q;
    xi_d      = xi_q;
    yi_d      = yi_q;
    srow_d    = srow_q;
    cell_d    = cell_q;
    tk_d      = tk_q;
    tm_d      = tm_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    nsel_d    = nsel_q;
    n_d       = n_q;
    d_d       = d_q;
    p_d       = p_q;
    q_d       = q_q;
    fail_d    = fail_q;
    cnt_d     = cnt_q;
    div_start = 1'b0;
    srch_idx  = '0;
    ov_d      = ov_q & out_stall_i;
    om_d      = om_q;
    otc_d     = otc_q;
    otr_d     = otr_q;
    omn_d     = omn_q;
    osc_d     = osc_q;
    osr_d     = osr_q;

    case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == OP_CLEAR)) begin
          cnt_d = '0;
        end
        if (accept && (opcode_i == OP_MAP)) begin
          col_d  = pixel_col_i;
          row_d  = pixel_row_i;
          u_d    = $signed({4'b0000, pixel_col_i}) - 16'(offx_q) + 16'sd1;
          v_d    = $signed({4'b0000, pixel_row_i}) - 16'(offy_q) + 16'sd1;
          fail_d = 1'b0;
          k_d    = '0;
          srow_d = 1'b0;
          tk_d   = '0;
          tm_d   = '0;
          acc_d  = '0;
          cell_d = '0;
          state_d = mode_q ? S_SRD : S_TRD;
        end
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        // Count boundaries at or below the pixel, stop at the first above
        if ((srch_pos >= srch_bnd) && (k_inc != srch_n)) begin
          k_d     = k_inc;
          state_d = S_SRD;
        end else begin
          srch_idx = (srch_pos >= srch_bnd) ? k_q : k_q;
          k_d      = '0;
          if (srow_q) begin
            yi_d    = srch_idx;
            state_d = S_CELL;
          end else begin
            xi_d    = srch_idx;
            srow_d  = 1'b1;
            state_d = S_SRD;
          end
        end
      end
      S_CELL: begin
        cell_d  = CW'(32'(yi_q) + 32'(xi_q) * 32'(gc));
        state_d = S_TRD;
      end
      S_TRD: begin
        state_d = S_TMUL;
      end
      S_TMUL: begin
        prod_d  = $signed(coef_rd) * mult;
        state_d = S_TACC;
      end
      S_TACC: begin
        if (tm_q == 2'd2) begin
          case (tk_q)
            2'd0:    t0_d = acc_sum;
            2'd1:    t1_d = acc_sum;
            default: t2_d = acc_sum;
          endcase
          acc_d = '0;
          tm_d  = '0;
          if (tk_q == 2'd2) begin
            nsel_d  = 1'b0;
            state_d = S_P1;
          end else begin
            tk_d    = tk_q + 2'd1;
            state_d = S_TRD;
          end
        end else begin
          acc_d   = acc_sum;
          tm_d    = tm_q + 2'd1;
          state_d = S_TRD;
        end
      end
      S_P1: begin
        // Form 2*num - den over 2*den
        if (t2_q == '0) begin
          fail_d  = 1'b1;
          state_d = S_CHECK;
        end else begin
          n_d     = (DW'(num_s) <<< 1) - DW'(t2_q);
          d_d     = DW'(t2_q) <<< 1;
          state_d = S_P2;
        end
      end
      S_P2: begin
        if (d_q[DW-1]) begin
          n_d = -n_q;
          d_d = -d_q;
        end
        state_d = S_P3;
      end
      S_P3: begin
        if (n_q[DW-1] || (n_q == '0)) begin
          fail_d  = 1'b1;
          state_d = S_CHECK;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (div_sts.ovf) begin
            fail_d  = 1'b1;
            state_d = S_CHECK;
          end else if (!nsel_q) begin
            p_d     = res;
            nsel_d  = 1'b1;
            state_d = S_P1;
          end else begin
            q_d     = res;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // Load the result register once it is free
        if (out_free) begin
          ov_d  = 1'b1;
          osc_d = col_q;
          osr_d = row_q;
          if (hit) begin
            om_d  = 1'b1;
            otc_d = 12'(p_q);
            otr_d = 12'(q_q);
            if (cnt_q != CNT_MAX) begin
              cnt_d = cnt_q + 24'd1;
              omn_d = cnt_q + 24'd1;
            end else begin
              omn_d = cnt_q;
            end
          end else begin
            om_d  = 1'b0;
            otc_d = '0;
            otr_d = '0;
            omn_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      fail_q  <= 1'b0;
      k_q     <= '0;
      srow_q  <= 1'b0;
      tk_q    <= '0;
      tm_q    <= '0;
      nsel_q  <= 1'b0;
      mode_q  <= 1'b0;
      offx_q  <= '0;
      offy_q  <= '0;
      tw_q    <= 13'd4096;
      th_q    <= 13'd4096;
      gcols_q <= 7'd1;
      grows_q <= 7'd1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      fail_q  <= fail_d;
      k_q     <= k_d;
      srow_q  <= srow_d;
      tk_q    <= tk_d;
      tm_q    <= tm_d;
      nsel_q  <= nsel_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_MODE:     mode_q  <= cfg_data_i[0];
          CFG_OFFSET_X:      offx_q  <= $signed(cfg_data_i);
          CFG_OFFSET_Y:      offy_q  <= $signed(cfg_data_i);
          CFG_TARGET_WIDTH:  tw_q    <= cfg_data_i[12:0];
          CFG_TARGET_HEIGHT: th_q    <= cfg_data_i[12:0];
          CFG_GRID_COLUMNS:  gcols_q <= cfg_data_i[6:0];
          CFG_GRID_ROWS:     grows_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    u_q    <= u_d;
    v_q    <= v_d;
    xi_q   <= xi_d;
    yi_q   <= yi_d;
    cell_q <= cell_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    n_q    <= n_d;
    d_q    <= d_d;
    p_q    <= p_d;
    q_q    <= q_d;
    om_q   <= om_d;
    otc_q  <= otc_d;
    otr_q  <= otr_d;
    omn_q  <= omn_d;
    osc_q  <= osc_d;
    osr_q  <= osr_d;
  end

  // Coefficient table
  pwom_ram #(
    .DEPTH (SLOTS),
    .WIDTH (COEFF_WIDTH),
    .AW    (CAW)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (CAW'(table_index_i)),
    .wdata_i (load_value_i[COEFF_WIDTH-1:0]),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rd)
  );

  // Column boundaries
  pwom_ram #(
    .DEPTH (GRID_MAX),
    .WIDTH (13),
    .AW    (BAW)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (cb_we),
    .waddr_i (BAW'(table_index_i)),
    .wdata_i (bnd_wdata),
    .re_i    (bnd_re),
    .raddr_i (k_q[BAW-1:0]),
    .rdata_o (cb_rd)
  );

  // Row boundaries
  pwom_ram #(
    .DEPTH (GRID_MAX),
    .WIDTH (13),
    .AW    (BAW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (BAW'(table_index_i)),
    .wdata_i (bnd_wdata),
    .re_i    (bnd_re),
    .raddr_i (k_q[BAW-1:0]),
    .rdata_o (rb_rd)
  );

  // Shared divider for both coordinates
  pwom_div #(
    .DW (DW),
    .QB (QB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (DW'(d_q)),
    .sts_o   (div_sts),
    .quo_o   (div_quo)
  );

  assign out_valid_o    = ov_q;
  assign matched_o      = om_q;
  assign target_col_o   = otc_q;
  assign target_row_o   = otr_q;
  assign match_number_o = omn_q;
  assign source_col_o   = osc_q;
  assign source_row_o   = osr_q;

endmodule

FILE: rtl/pwom_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// Used for the coefficient table and the two boundary lists. No dependencies.
module pwom_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 13,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pwom_div.sv
// Restoring divider, one quotient bit a cycle, with range check up front.
// Depends on pwom_pkg for the status type.
module pwom_div #(
  parameter int DW = 84,
  parameter int QB = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DW-1:0]         num_i,
  input  logic [DW-1:0]         den_i,
  output pwom_pkg::pwom_div_sts_t sts_o,
  output logic [QB-1:0]         quo_o
);
  import pwom_pkg::*;

  localparam int XW = DW + QB;
  localparam int CNTW = $clog2(QB + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [XW-1:0]   dsh_q, dsh_d;
  logic [QB-1:0]   quo_q, quo_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic            ovf_q, ovf_d;
  logic            fits;

  // Quotient fits in QB bits when num < den * 2^QB
  assign fits = {{QB{1'b0}}, num_i} < {den_i, {QB{1'b0}}};

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    if (start_i) begin
      rem_d = num_i;
      dsh_d = XW'(den_i) << (QB - 1);
      quo_d = '0;
      cnt_d = CNTW'(QB);
      ovf_d = ~fits;
      run_d = fits;
      done_d = ~fits;
    end else if (run_q) begin
      // One trial subtraction a cycle
      if (XW'(rem_q) >= dsh_q) begin
        rem_d = rem_q - DW'(dsh_q);
        quo_d = {quo_q[QB-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QB-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.ovf  = ovf_q;
  assign quo_o      = quo_q;

endmodule
